// ===== design/earm_pkg.sv =====
// package for the euler angle rotation matrix unit
// holds default widths, cordic constants and the arctangent table; no dependencies
package earm_pkg;

   localparam int ANGLE_BITS_DEF      = 16;
   localparam int VALUE_BITS_DEF      = 16;
   localparam int TRIG_ITERATIONS_DEF = 16;

   // cordic datapath width: q2.30 plus guard bits
   localparam int CW = 34;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

   function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002;
         5'd29: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return $signed({2'b00, r});
   endfunction

endpackage

// ===== design/earm_trig.sv =====
// pipelined cordic cosine/sine for one angle, one stage per iteration
// depends on earm_pkg
module earm_trig #(
   parameter int ANGLE_BITS      = earm_pkg::ANGLE_BITS_DEF,
   parameter int VALUE_BITS      = earm_pkg::VALUE_BITS_DEF,
   parameter int TRIG_ITERATIONS = earm_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [ANGLE_BITS-1:0]        angle,
   output logic signed [VALUE_BITS-1:0] cos_out,
   output logic signed [VALUE_BITS-1:0] sin_out
);
   localparam int CW = earm_pkg::CW;
   localparam int N  = TRIG_ITERATIONS;
   localparam int F  = VALUE_BITS - 1;
   localparam int QW = CW + 2;

   logic signed [CW-1:0] x_ff [N+1];
   logic signed [CW-1:0] y_ff [N+1];
   logic signed [CW-1:0] z_ff [N+1];
   logic                 neg_ff [N+1];

   logic [31:0] a_wide;
   logic [31:0] a_rot;
   logic        neg_in;

   always_comb begin
      a_wide = 32'(angle) << (32 - ANGLE_BITS);
      neg_in = (a_wide[31:30] == 2'b01) || (a_wide[31:30] == 2'b10);
      a_rot  = neg_in ? (a_wide + 32'h80000000) : a_wide;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= earm_pkg::CORDIC_GAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= CW'($signed(a_rot));
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [CW-1:0] x_in, y_in, z_in;
      always_comb begin
         if (i < 32 && !z_ff[i][CW-1]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - earm_pkg::atan_entry(5'(i));
         end else if (i < 32) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + earm_pkg::atan_entry(5'(i));
         end else begin
            x_in = x_ff[i];
            y_in = y_ff[i];
            z_in = z_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   function automatic logic signed [VALUE_BITS-1:0] quant(input logic signed [CW-1:0] v);
      logic signed [QW-1:0] w;
      logic signed [QW-1:0] hi;
      logic signed [QW-1:0] lo;
      hi = QW'((64'sd1 <<< F) - 1);
      lo = -hi - QW'(1);
      if (F < 30) begin
         w = (QW'(v) + (QW'(1) <<< ((F < 30) ? (29 - F) : 0))) >>> ((F < 30) ? (30 - F) : 0);
      end else if (F > 30) begin
         w = QW'(v) <<< 1;
      end else begin
         w = QW'(v);
      end
      if (w > hi) w = hi;
      else if (w < lo) w = lo;
      return w[VALUE_BITS-1:0];
   endfunction

   logic signed [CW-1:0] xf, yf;
   always_comb begin
      xf = neg_ff[N] ? -x_ff[N] : x_ff[N];
      yf = neg_ff[N] ? -y_ff[N] : y_ff[N];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_out <= quant(xf);
         sin_out <= quant(yf);
      end
   end
endmodule

// ===== design/earm_combine.sv =====
// three-stage product and sum network forming the nine matrix entries
// depends on earm_pkg
module earm_combine #(
   parameter int VALUE_BITS = earm_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic signed [VALUE_BITS-1:0] c1, s1, c2, s2, c3, s3,
   output logic signed [VALUE_BITS-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33
);
   localparam int F  = VALUE_BITS - 1;
   localparam int PW = 2 * VALUE_BITS;
   localparam int SW = VALUE_BITS + 2;

   function automatic logic signed [VALUE_BITS:0] fmul(input logic signed [VALUE_BITS:0] a,
                                                       input logic signed [VALUE_BITS:0] b);
      logic signed [PW+1:0] p;
      p = (PW+2)'(a) * (PW+2)'(b) + ((PW+2)'(1) <<< (F - 1));
      p = p >>> F;
      return p[VALUE_BITS:0];
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi;
      logic signed [SW-1:0] lo;
      hi = SW'((64'sd1 <<< F) - 1);
      lo = -hi - SW'(1);
      if (v > hi) return hi[VALUE_BITS-1:0];
      if (v < lo) return lo[VALUE_BITS-1:0];
      return v[VALUE_BITS-1:0];
   endfunction

   // factors widened by one bit so a product of -1.0 by -1.0 fits
   logic signed [VALUE_BITS:0] c1x, s1x, c2x, s2x, c3x, s3x;

   always_comb begin
      c1x = (VALUE_BITS+1)'(c1);
      s1x = (VALUE_BITS+1)'(s1);
      c2x = (VALUE_BITS+1)'(c2);
      s2x = (VALUE_BITS+1)'(s2);
      c3x = (VALUE_BITS+1)'(c3);
      s3x = (VALUE_BITS+1)'(s3);
   end

   // stage a: pair products; stage b: triple products; stage c: sums and saturation
   logic signed [VALUE_BITS:0] c1c3_ff, c2s1_ff, c3s1_ff, c1c2_ff, s2s3_ff, c1s3_ff;
   logic signed [VALUE_BITS:0] c2c3_ff, s1s3_ff, c3s2_ff, s1s2_ff, c1s2_ff;
   logic signed [VALUE_BITS:0] s1a_ff, c3a_ff, s3a_ff, c2a_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c1c3_ff <= fmul(c1x, c3x);
         c2s1_ff <= fmul(c2x, s1x);
         c3s1_ff <= fmul(c3x, s1x);
         c1c2_ff <= fmul(c1x, c2x);
         s2s3_ff <= fmul(s2x, s3x);
         c1s3_ff <= fmul(c1x, s3x);
         c2c3_ff <= fmul(c2x, c3x);
         s1s3_ff <= fmul(s1x, s3x);
         c3s2_ff <= fmul(c3x, s2x);
         s1s2_ff <= fmul(s1x, s2x);
         c1s2_ff <= fmul(c1x, s2x);
         s1a_ff  <= s1x;
         c3a_ff  <= c3x;
         s3a_ff  <= s3x;
         c2a_ff  <= c2x;
      end
   end

   logic signed [VALUE_BITS:0] t11_ff, t12_ff, t21_ff, t22_ff;
   logic signed [VALUE_BITS:0] p11_ff, p12_ff, p13_ff, p21_ff, p22_ff, p23_ff;
   logic signed [VALUE_BITS:0] p31_ff, p32_ff, p33_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         t11_ff <= fmul(c2s1_ff, s3a_ff);
         t12_ff <= fmul(c1c2_ff, s3a_ff);
         t21_ff <= fmul(c2c3_ff, s1a_ff);
         t22_ff <= fmul(c1c2_ff, c3a_ff);
         p11_ff <= c1c3_ff;
         p12_ff <= c3s1_ff;
         p13_ff <= s2s3_ff;
         p21_ff <= c1s3_ff;
         p22_ff <= s1s3_ff;
         p23_ff <= c3s2_ff;
         p31_ff <= s1s2_ff;
         p32_ff <= c1s2_ff;
         p33_ff <= c2a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e11 <= sat(SW'(p11_ff) - SW'(t11_ff));
         e12 <= sat(SW'(p12_ff) + SW'(t12_ff));
         e13 <= sat(SW'(p13_ff));
         e21 <= sat(-SW'(p21_ff) - SW'(t21_ff));
         e22 <= sat(SW'(t22_ff) - SW'(p22_ff));
         e23 <= sat(SW'(p23_ff));
         e31 <= sat(SW'(p31_ff));
         e32 <= sat(-SW'(p32_ff));
         e33 <= sat(SW'(p33_ff));
      end
   end
endmodule

// ===== design/euler_angle_rotation_matrix_unit.sv =====
// Takes three ZXZ Euler angles in binary angle units (a full turn is 2^ANGLE_BITS) and
// returns the nine Q1.(VALUE_BITS-1) entries of the rotation matrix. One item is accepted
// every cycle while the pipeline is not halted; the pipeline is formed by the CORDIC pipeline
// (one stage per iteration plus entry and quantizing) and three product/sum stages.
// The whole pipeline halts while the result is stalled. Depends on earm_pkg,
// earm_trig and earm_combine.
module euler_angle_rotation_matrix_unit #(
   parameter int ANGLE_BITS      = earm_pkg::ANGLE_BITS_DEF,
   parameter int VALUE_BITS      = earm_pkg::VALUE_BITS_DEF,
   parameter int TRIG_ITERATIONS = earm_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [ANGLE_BITS-1:0] req_angle_first,
   input  logic signed [ANGLE_BITS-1:0] req_angle_second,
   input  logic signed [ANGLE_BITS-1:0] req_angle_third,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_entry_11,
   output logic signed [VALUE_BITS-1:0] rsp_entry_12,
   output logic signed [VALUE_BITS-1:0] rsp_entry_13,
   output logic signed [VALUE_BITS-1:0] rsp_entry_21,
   output logic signed [VALUE_BITS-1:0] rsp_entry_22,
   output logic signed [VALUE_BITS-1:0] rsp_entry_23,
   output logic signed [VALUE_BITS-1:0] rsp_entry_31,
   output logic signed [VALUE_BITS-1:0] rsp_entry_32,
   output logic signed [VALUE_BITS-1:0] rsp_entry_33
);
   localparam int DEPTH = TRIG_ITERATIONS + 5;

   logic             advance;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   // global stall: a bubble at the output still lets the line move
   assign advance   = !(rsp_stall && valid_ff[DEPTH-1]);
   assign req_stall = !advance;
   assign rsp_valid = valid_ff[DEPTH-1];
   assign valid_in  = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   logic signed [VALUE_BITS-1:0] c1, s1, c2, s2, c3, s3;

   earm_trig #(.ANGLE_BITS(ANGLE_BITS), .VALUE_BITS(VALUE_BITS),
               .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig1 (
      .clock(clock), .advance(advance), .angle(req_angle_first),
      .cos_out(c1), .sin_out(s1));
   earm_trig #(.ANGLE_BITS(ANGLE_BITS), .VALUE_BITS(VALUE_BITS),
               .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig2 (
      .clock(clock), .advance(advance), .angle(req_angle_second),
      .cos_out(c2), .sin_out(s2));
   earm_trig #(.ANGLE_BITS(ANGLE_BITS), .VALUE_BITS(VALUE_BITS),
               .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig3 (
      .clock(clock), .advance(advance), .angle(req_angle_third),
      .cos_out(c3), .sin_out(s3));

   earm_combine #(.VALUE_BITS(VALUE_BITS)) u_combine (
      .clock(clock), .advance(advance),
      .c1(c1), .s1(s1), .c2(c2), .s2(s2), .c3(c3), .s3(s3),
      .e11(rsp_entry_11), .e12(rsp_entry_12), .e13(rsp_entry_13),
      .e21(rsp_entry_21), .e22(rsp_entry_22), .e23(rsp_entry_23),
      .e31(rsp_entry_31), .e32(rsp_entry_32), .e33(rsp_entry_33));

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_11) && $stable(rsp_entry_33))
      else $error("stalled item changed");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      !req_stall |=> valid_ff[0] == $past(req_valid))
      else $error("valid lost on entry");
endmodule
